// ===== hdl/mbrpt_pkg.sv =====
`timescale 1ns / 1ps

package mbrpt_pkg;

  localparam int TABLE_BASE  = 446;
  localparam int SIG_LOW_AT  = 510;
  localparam int SIG_HIGH_AT = 511;
  localparam logic [7:0] SIG_LOW_BYTE  = 8'h55;
  localparam logic [7:0] SIG_HIGH_BYTE = 8'hAA;
  localparam logic [2:0] RESET_MAX_ENTRIES = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SIG  = 2'd1;
  localparam logic [1:0] ST_BAD_CFG = 2'd2;

  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0]  ptype;
    logic [31:0] start;
    logic [31:0] length;
  } mbrpt_entry_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] limit;
  } mbrpt_cmd_t;

  function automatic logic is_fat32(input logic [7:0] t);
    return (t == 8'h0B) || (t == 8'h0C) || (t == 8'h1B) || (t == 8'h1C);
  endfunction

  function automatic logic is_fat(input logic [7:0] t);
    return is_fat32(t) || (t == 8'h01) || (t == 8'h04) || (t == 8'h06) ||
           (t == 8'h0E) || (t == 8'h11) || (t == 8'h14) || (t == 8'h16) ||
           (t == 8'h1E);
  endfunction

endpackage

// ===== hdl/mbr_partition_table_parser_unit.sv =====
`timescale 1ns / 1ps

// Parses the partition table of sector zero from a byte stream, one byte per cycle.
// The input stays open at full rate; it stalls only while two finished sectors
// still wait in the two-deep command queue between the byte front end and the
// result sequencer. After the byte at offset 511 the sequencer scans the table
// slots in turn and then emits a closing summary, holding while an unpopped
// result fills the output. The result port is a single output register that
// another result refills in the cycle it is popped. No clearing pass follows
// reset.
module mbr_partition_table_parser_unit #(
  parameter int ENTRY_SLOTS  = 4,
  parameter int SECTOR_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_sector_byte,
  input  logic        in_first_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_result_kind,
  output logic [1:0]  out_scan_status,
  output logic [7:0]  out_partition_type,
  output logic [31:0] out_start_lba,
  output logic [31:0] out_block_count,
  output logic        out_fat32_flag,
  output logic        out_fat_flag,
  output logic [2:0]  out_found_count,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_max_entries
);
  import mbrpt_pkg::*;

  logic                           cmd_push;
  mbrpt_cmd_t                     push_hdr;
  mbrpt_entry_t [ENTRY_SLOTS-1:0] push_entries;
  logic                           q_full;
  logic                           q_empty;
  logic                           cmd_pop;
  mbrpt_cmd_t                     head_hdr;
  mbrpt_entry_t [ENTRY_SLOTS-1:0] head_entries;

  assign cfg_ready = 1'b1;

  mbrpt_front #(
    .ENTRY_SLOTS (ENTRY_SLOTS),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_sector_byte (in_sector_byte),
    .in_first_byte  (in_first_byte),
    .in_full        (in_full),
    .cfg_valid      (cfg_valid),
    .cfg_max_entries(cfg_max_entries),
    .cmd_push       (cmd_push),
    .cmd_hdr        (push_hdr),
    .cmd_entries    (push_entries),
    .q_full         (q_full)
  );

  mbrpt_cmdq #(
    .ENTRY_SLOTS(ENTRY_SLOTS)
  ) u_cmdq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (cmd_push),
    .push_hdr    (push_hdr),
    .push_entries(push_entries),
    .full        (q_full),
    .pop         (cmd_pop),
    .empty       (q_empty),
    .head_hdr    (head_hdr),
    .head_entries(head_entries)
  );

  mbrpt_back #(
    .ENTRY_SLOTS(ENTRY_SLOTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_empty         (q_empty),
    .cmd_hdr           (head_hdr),
    .cmd_entries       (head_entries),
    .cmd_pop           (cmd_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_result_kind   (out_result_kind),
    .out_scan_status   (out_scan_status),
    .out_partition_type(out_partition_type),
    .out_start_lba     (out_start_lba),
    .out_block_count   (out_block_count),
    .out_fat32_flag    (out_fat32_flag),
    .out_fat_flag      (out_fat_flag),
    .out_found_count   (out_found_count),
    .out_last_result   (out_last_result)
  );

  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !q_full)
    else $error("Sector command transfer while the command queue is full");

  a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_found_count <= 3'(ENTRY_SLOTS))
    else $error("Reported count exceeds the number of table slots");

  a_failed_scan_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_scan_status != ST_OK) |-> (out_found_count == 3'd0))
    else $error("Failed scan reports a nonzero count");

  a_summary_last : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last_result == (out_result_kind == KIND_SUMMARY)))
    else $error("Last-result marker disagrees with the result kind");

endmodule

// ===== hdl/mbrpt_front.sv =====
`timescale 1ns / 1ps

module mbrpt_front #(
  parameter int ENTRY_SLOTS  = 4,
  parameter int SECTOR_BYTES = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  logic [7:0]                           in_sector_byte,
  input  logic                                 in_first_byte,
  output logic                                 in_full,
  input  logic                                 cfg_valid,
  input  logic [2:0]                           cfg_max_entries,
  output logic                                 cmd_push,
  output mbrpt_pkg::mbrpt_cmd_t                cmd_hdr,
  output mbrpt_pkg::mbrpt_entry_t [ENTRY_SLOTS-1:0] cmd_entries,
  input  logic                                 q_full
);
  import mbrpt_pkg::*;

  localparam int OFS_W = $clog2(SECTOR_BYTES);

  logic [OFS_W-1:0] offset_r;
  logic [OFS_W-1:0] offset_nxt;
  logic [OFS_W-1:0] off_w;
  logic [OFS_W-1:0] rel_w;
  logic [3:0]       pos_w;
  logic             accept_w;
  logic             in_table_w;
  logic [2:0]       max_entries_r;
  logic [7:0]       sig_low_r;
  mbrpt_entry_t     entry_r [ENTRY_SLOTS];

  assign in_full    = q_full;
  assign accept_w   = in_push && !q_full;
  assign off_w      = in_first_byte ? '0 : offset_r;
  assign offset_nxt = (off_w == OFS_W'(SECTOR_BYTES - 1)) ? '0 : off_w + 1'b1;
  assign rel_w      = off_w - OFS_W'(TABLE_BASE);
  assign pos_w      = rel_w[3:0];
  assign in_table_w = (off_w >= OFS_W'(TABLE_BASE)) &&
                      (rel_w[OFS_W-1:4] < (OFS_W-4)'(ENTRY_SLOTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r      <= '0;
      max_entries_r <= RESET_MAX_ENTRIES;
    end else begin
      if (accept_w) begin
        offset_r <= offset_nxt;
      end
      if (cfg_valid) begin
        max_entries_r <= cfg_max_entries;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_w && off_w == OFS_W'(SIG_LOW_AT)) begin
      sig_low_r <= in_sector_byte;
    end
  end

  for (genvar g = 0; g < ENTRY_SLOTS; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (accept_w && in_table_w && rel_w[OFS_W-1:4] == (OFS_W-4)'(g)) begin
        if (pos_w == 4'd4) begin
          entry_r[g].ptype <= in_sector_byte;
        end else if (pos_w[3:2] == 2'b10) begin
          entry_r[g].start[{pos_w[1:0], 3'b000} +: 8] <= in_sector_byte;
        end else if (pos_w[3:2] == 2'b11) begin
          entry_r[g].length[{pos_w[1:0], 3'b000} +: 8] <= in_sector_byte;
        end
      end
    end
    assign cmd_entries[g] = entry_r[g];
  end

  // The sector's last byte closes the scan; its command carries a copy of the table.
  assign cmd_push      = accept_w && (off_w == OFS_W'(SIG_HIGH_AT));

  always_comb begin
    cmd_hdr.limit = max_entries_r;
    if (max_entries_r == 3'd0) begin
      cmd_hdr.status = ST_BAD_CFG;
    end else if (sig_low_r == SIG_LOW_BYTE && in_sector_byte == SIG_HIGH_BYTE) begin
      cmd_hdr.status = ST_OK;
    end else begin
      cmd_hdr.status = ST_NO_SIG;
    end
  end

endmodule

// ===== hdl/mbrpt_cmdq.sv =====
`timescale 1ns / 1ps

module mbrpt_cmdq #(
  parameter int ENTRY_SLOTS = 4
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  input  mbrpt_pkg::mbrpt_cmd_t                     push_hdr,
  input  mbrpt_pkg::mbrpt_entry_t [ENTRY_SLOTS-1:0] push_entries,
  output logic                                      full,
  input  logic                                      pop,
  output logic                                      empty,
  output mbrpt_pkg::mbrpt_cmd_t                     head_hdr,
  output mbrpt_pkg::mbrpt_entry_t [ENTRY_SLOTS-1:0] head_entries
);
  import mbrpt_pkg::*;

  mbrpt_cmd_t                     hdr_mem [2];
  mbrpt_entry_t [ENTRY_SLOTS-1:0] ent_mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      hdr_mem[wr_ptr_r] <= push_hdr;
      ent_mem[wr_ptr_r] <= push_entries;
    end
  end

  assign head_hdr     = hdr_mem[rd_ptr_r];
  assign head_entries = ent_mem[rd_ptr_r];

endmodule

// ===== hdl/mbrpt_back.sv =====
`timescale 1ns / 1ps

module mbrpt_back #(
  parameter int ENTRY_SLOTS = 4
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cmd_empty,
  input  mbrpt_pkg::mbrpt_cmd_t                     cmd_hdr,
  input  mbrpt_pkg::mbrpt_entry_t [ENTRY_SLOTS-1:0] cmd_entries,
  output logic                                      cmd_pop,
  output logic                                      out_empty,
  input  logic                                      out_pop,
  output logic                                      out_result_kind,
  output logic [1:0]                                out_scan_status,
  output logic [7:0]                                out_partition_type,
  output logic [31:0]                               out_start_lba,
  output logic [31:0]                               out_block_count,
  output logic                                      out_fat32_flag,
  output logic                                      out_fat_flag,
  output logic [2:0]                                out_found_count,
  output logic                                      out_last_result
);
  import mbrpt_pkg::*;

  localparam int IDX_W  = $clog2(ENTRY_SLOTS + 1);
  localparam int SLOT_W = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;

  logic [IDX_W-1:0] idx_r;
  logic [2:0]       found_r;
  logic             out_valid_r;
  logic             out_free_w;
  logic             step_w;
  logic             scan_w;
  logic             slot_used_w;
  mbrpt_entry_t     cur_w;

  assign out_empty  = !out_valid_r;
  assign out_free_w = !out_valid_r || out_pop;
  assign step_w     = !cmd_empty && out_free_w;
  assign cur_w      = cmd_entries[idx_r[SLOT_W-1:0]];
  assign scan_w     = (cmd_hdr.status == ST_OK) && (idx_r < IDX_W'(ENTRY_SLOTS)) &&
                      (found_r < cmd_hdr.limit);
  assign slot_used_w = (cur_w.ptype != 8'd0) && (cur_w.length != 32'd0);
  assign cmd_pop    = step_w && !scan_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      if (step_w) begin
        if (scan_w) begin
          idx_r <= idx_r + 1'b1;
          if (slot_used_w) begin
            found_r     <= found_r + 3'd1;
            out_valid_r <= 1'b1;
          end
        end else begin
          idx_r       <= '0;
          found_r     <= '0;
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_w) begin
      if (scan_w) begin
        if (slot_used_w) begin
          out_result_kind    <= KIND_ENTRY;
          out_scan_status    <= ST_OK;
          out_partition_type <= cur_w.ptype;
          out_start_lba      <= cur_w.start;
          out_block_count    <= cur_w.length;
          out_fat32_flag     <= is_fat32(cur_w.ptype);
          out_fat_flag       <= is_fat(cur_w.ptype);
          out_found_count    <= 3'd0;
          out_last_result    <= 1'b0;
        end
      end else begin
        out_result_kind    <= KIND_SUMMARY;
        out_scan_status    <= cmd_hdr.status;
        out_partition_type <= 8'd0;
        out_start_lba      <= 32'd0;
        out_block_count    <= 32'd0;
        out_fat32_flag     <= 1'b0;
        out_fat_flag       <= 1'b0;
        out_found_count    <= found_r;
        out_last_result    <= 1'b1;
      end
    end
  end

endmodule

// ===== tb/mbrpt_result_check.sv =====
`timescale 1ns / 1ps

module mbrpt_result_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_sector_byte,
  input  logic        in_first_byte,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic        out_result_kind,
  input  logic [1:0]  out_scan_status,
  input  logic [7:0]  out_partition_type,
  input  logic [31:0] out_start_lba,
  input  logic [31:0] out_block_count,
  input  logic        out_fat32_flag,
  input  logic        out_fat_flag,
  input  logic [2:0]  out_found_count,
  input  logic        out_last_result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_max_entries,
  output int          fail_count,
  output int          pending_results,
  output int          results_seen
);

  import mbrpt_pkg::*;

  localparam int TABLE_SLOTS = 4;
  localparam int SLOT_BYTES  = 16;
  localparam int PRINT_LIMIT = 60;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  ptype;
    logic [31:0] lba;
    logic [31:0] blocks;
    logic        f32;
    logic        fat;
    logic [2:0]  found;
    logic        last;
  } scan_result_t;

  scan_result_t expected_results[$];

  logic [8:0]  byte_pos;
  logic [7:0]  slot_type [TABLE_SLOTS];
  logic [31:0] slot_lba [TABLE_SLOTS];
  logic [31:0] slot_len [TABLE_SLOTS];
  logic [7:0]  sig_first;
  logic [2:0]  report_limit;

  function automatic logic fat32_code(input logic [7:0] t);
    case (t)
      8'h0B, 8'h0C, 8'h1B, 8'h1C: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic any_fat_code(input logic [7:0] t);
    case (t)
      8'h01, 8'h04, 8'h06, 8'h0E, 8'h11, 8'h14, 8'h16, 8'h1E: return 1'b1;
      default: return fat32_code(t);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic first);
    logic [8:0]   pos;
    int           rel;
    int           slot;
    int           field;
    int           found;
    logic [1:0]   status;
    scan_result_t r;
    if (first) begin
      byte_pos = '0;
    end
    pos = byte_pos;
    byte_pos = byte_pos + 9'd1;
    if (pos >= TABLE_BASE && pos < TABLE_BASE + TABLE_SLOTS * SLOT_BYTES) begin
      rel = pos - TABLE_BASE;
      slot = rel / SLOT_BYTES;
      field = rel % SLOT_BYTES;
      if (field == 4) begin
        slot_type[slot] = b;
      end else if (field >= 8 && field < 12) begin
        slot_lba[slot][8 * (field - 8) +: 8] = b;
      end else if (field >= 12) begin
        slot_len[slot][8 * (field - 12) +: 8] = b;
      end
    end
    if (pos == SIG_LOW_AT) begin
      sig_first = b;
    end
    if (pos == SIG_HIGH_AT) begin
      found = 0;
      if (report_limit == 3'd0) begin
        status = ST_BAD_CFG;
      end else if (sig_first != SIG_LOW_BYTE || b != SIG_HIGH_BYTE) begin
        status = ST_NO_SIG;
      end else begin
        status = ST_OK;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (found < report_limit && slot_type[i] != 8'h00 && slot_len[i] != 32'h0) begin
            r = '0;
            r.kind = KIND_ENTRY;
            r.ptype = slot_type[i];
            r.lba = slot_lba[i];
            r.blocks = slot_len[i];
            r.f32 = fat32_code(slot_type[i]);
            r.fat = any_fat_code(slot_type[i]);
            expected_results.push_back(r);
            found++;
          end
        end
      end
      r = '0;
      r.kind = KIND_SUMMARY;
      r.status = status;
      r.found = 3'(found);
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  task automatic check_result();
    scan_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result transfer with no result expected");
    end else begin
      want = expected_results.pop_front();
      check_field("result_kind", 32'(out_result_kind), 32'(want.kind));
      check_field("scan_status", 32'(out_scan_status), 32'(want.status));
      check_field("partition_type", 32'(out_partition_type), 32'(want.ptype));
      check_field("start_lba", out_start_lba, want.lba);
      check_field("block_count", out_block_count, want.blocks);
      check_field("fat32_flag", 32'(out_fat32_flag), 32'(want.f32));
      check_field("fat_flag", 32'(out_fat_flag), 32'(want.fat));
      check_field("found_count", 32'(out_found_count), 32'(want.found));
      check_field("last_result", 32'(out_last_result), 32'(want.last));
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      byte_pos = '0;
      sig_first = '0;
      report_limit = RESET_MAX_ENTRIES;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_type[i] = '0;
        slot_lba[i] = '0;
        slot_len[i] = '0;
      end
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        report_limit = cfg_max_entries;
      end
      if (out_pop && !out_empty) begin
        check_result();
      end
      if (in_push && !in_full) begin
        take_byte(in_sector_byte, in_first_byte);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  import mbrpt_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int SECTOR_LEN    = 512;
  localparam int PHASES        = 7;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_sector_byte = 8'h00;
  logic        in_first_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_result_kind;
  logic [1:0]  out_scan_status;
  logic [7:0]  out_partition_type;
  logic [31:0] out_start_lba;
  logic [31:0] out_block_count;
  logic        out_fat32_flag;
  logic        out_fat_flag;
  logic [2:0]  out_found_count;
  logic        out_last_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_max_entries = 3'd0;

  int fail_count;
  int pending_results;
  int results_seen;
  int send_idle = 6;
  int recv_idle = 51;

  logic [7:0]  tbl_type [4];
  logic [31:0] tbl_lba [4];
  logic [31:0] tbl_cnt [4];
  logic [7:0]  sig_lo;
  logic [7:0]  sig_hi;

  mbr_partition_table_parser_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_sector_byte     (in_sector_byte),
    .in_first_byte      (in_first_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_result_kind    (out_result_kind),
    .out_scan_status    (out_scan_status),
    .out_partition_type (out_partition_type),
    .out_start_lba      (out_start_lba),
    .out_block_count    (out_block_count),
    .out_fat32_flag     (out_fat32_flag),
    .out_fat_flag       (out_fat_flag),
    .out_found_count    (out_found_count),
    .out_last_result    (out_last_result),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_entries    (cfg_max_entries)
  );

  mbrpt_result_check result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_sector_byte     (in_sector_byte),
    .in_first_byte      (in_first_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_result_kind    (out_result_kind),
    .out_scan_status    (out_scan_status),
    .out_partition_type (out_partition_type),
    .out_start_lba      (out_start_lba),
    .out_block_count    (out_block_count),
    .out_fat32_flag     (out_fat32_flag),
    .out_fat_flag       (out_fat_flag),
    .out_found_count    (out_found_count),
    .out_last_result    (out_last_result),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_entries    (cfg_max_entries),
    .fail_count         (fail_count),
    .pending_results    (pending_results),
    .results_seen       (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_idle);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] fat_code(input int n);
    case (n)
      0: return 8'h01;
      1: return 8'h04;
      2: return 8'h06;
      3: return 8'h0E;
      4: return 8'h0B;
      5: return 8'h0C;
      6: return 8'h1B;
      7: return 8'h1C;
      8: return 8'h11;
      9: return 8'h14;
      10: return 8'h16;
      default: return 8'h1E;
    endcase
  endfunction

  function automatic logic [2:0] phase_limit(input int p);
    case (p)
      0: return 3'd3;
      1: return 3'd7;
      2: return 3'd0;
      3: return 3'd1;
      4: return 3'd5;
      5: return 3'd2;
      default: return 3'd4;
    endcase
  endfunction

  task automatic settle();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [2:0] limit);
    cfg_max_entries <= limit;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_sector_byte <= b;
    in_first_byte <= first;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_sector(input int nbytes, input logic mark, input int stray_pct);
    logic [7:0] b;
    logic       first;
    int         rel;
    for (int k = 0; k < nbytes; k++) begin
      b = 8'($urandom);
      if (k >= TABLE_BASE && k < SIG_LOW_AT) begin
        rel = k - TABLE_BASE;
        if (rel % 16 == 4) begin
          b = tbl_type[rel / 16];
        end else if (rel % 16 >= 8 && rel % 16 < 12) begin
          b = tbl_lba[rel / 16][8 * (rel % 16 - 8) +: 8];
        end else if (rel % 16 >= 12) begin
          b = tbl_cnt[rel / 16][8 * (rel % 16 - 12) +: 8];
        end
      end else if (k == SIG_LOW_AT) begin
        b = sig_lo;
      end else if (k == SIG_HIGH_AT) begin
        b = sig_hi;
      end
      first = (k == 0) ? mark : ($urandom_range(99) < stray_pct);
      send_byte(b, first);
    end
  endtask

  task automatic load_table(input logic [7:0] t0, input logic [7:0] t1,
                            input logic [7:0] t2, input logic [7:0] t3);
    tbl_type[0] = t0;
    tbl_type[1] = t1;
    tbl_type[2] = t2;
    tbl_type[3] = t3;
    tbl_lba[0] = 32'h0000_0000;
    tbl_lba[1] = 32'hFFFF_FFFF;
    tbl_lba[2] = 32'h1234_5678;
    tbl_lba[3] = 32'h8000_0000;
    tbl_cnt[0] = 32'hFFFF_FFFF;
    tbl_cnt[1] = 32'h0000_0001;
    tbl_cnt[2] = 32'h00AB_CDEF;
    tbl_cnt[3] = 32'h7FFF_FFFF;
    sig_lo = SIG_LOW_BYTE;
    sig_hi = SIG_HIGH_BYTE;
  endtask

  task automatic roll_table();
    int pick;
    for (int s = 0; s < 4; s++) begin
      pick = $urandom_range(9);
      if (pick < 2) begin
        tbl_type[s] = 8'h00;
      end else if (pick < 6) begin
        tbl_type[s] = fat_code($urandom_range(11));
      end else begin
        tbl_type[s] = 8'($urandom);
      end
      tbl_lba[s] = $urandom;
      pick = $urandom_range(19);
      if (pick < 3) begin
        tbl_cnt[s] = 32'h0;
      end else if (pick == 3) begin
        tbl_cnt[s] = 32'hFFFF_FFFF;
      end else begin
        tbl_cnt[s] = $urandom;
      end
    end
    sig_lo = SIG_LOW_BYTE;
    sig_hi = SIG_HIGH_BYTE;
    pick = $urandom_range(9);
    if (pick == 0) begin
      sig_lo = 8'($urandom);
    end else if (pick == 1) begin
      sig_hi = 8'($urandom);
    end else if (pick == 2) begin
      sig_lo = SIG_HIGH_BYTE;
      sig_hi = SIG_LOW_BYTE;
    end
  endtask

  initial begin : stimulus
    int pick;
    int goal;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_limit(3'd4);
    load_table(8'h0B, 8'h0C, 8'h1B, 8'h1C);
    send_sector(SECTOR_LEN, 1'b1, 0);
    load_table(8'h01, 8'h04, 8'h06, 8'h0E);
    send_sector(SECTOR_LEN, 1'b1, 0);
    load_table(8'h11, 8'h14, 8'h16, 8'h1E);
    send_sector(SECTOR_LEN, 1'b1, 0);
    load_table(8'h00, 8'h83, 8'hFF, 8'h07);
    tbl_cnt[1] = 32'h0;
    send_sector(SECTOR_LEN, 1'b1, 0);
    load_table(8'h0C, 8'h07, 8'h83, 8'h0B);
    sig_hi = 8'hAB;
    send_sector(SECTOR_LEN, 1'b1, 0);
    sig_hi = SIG_HIGH_BYTE;
    sig_lo = 8'h54;
    send_sector(SECTOR_LEN, 1'b1, 0);
    load_table(8'h00, 8'h00, 8'h00, 8'h00);
    send_sector(SECTOR_LEN, 1'b0, 0);

    settle();
    set_limit(3'd0);
    load_table(8'h0B, 8'h06, 8'h83, 8'hFF);
    send_sector(SECTOR_LEN, 1'b1, 0);
    settle();
    set_limit(3'd7);
    send_sector(SECTOR_LEN, 1'b1, 0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_limit(phase_limit(p));
      if (p < 2) begin
        send_idle = 6;
        recv_idle = 51;
      end else if (p < 4) begin
        send_idle = 51;
        recv_idle = 6;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      goal = results_seen + 12;
      while (results_seen < goal) begin
        roll_table();
        pick = $urandom_range(9);
        if (pick < 8) begin
          send_sector(SECTOR_LEN, 1'b1, 0);
        end else if (pick == 8) begin
          send_sector(SECTOR_LEN, 1'b0, 0);
        end else begin
          send_sector($urandom_range(700, 1), 1'b1, 2);
        end
      end
    end

    in_push <= 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mbrpt_pkg.sv
hdl/mbrpt_front.sv
hdl/mbrpt_cmdq.sv
hdl/mbrpt_back.sv
hdl/mbr_partition_table_parser_unit.sv
tb/mbrpt_result_check.sv
tb/tb.sv
